### sv/kpsh_pkg.sv
// Package for the keypad scanner with hex line entry.
// Holds the input and result word layouts, field widths and the key-to-ASCII map.
// No dependencies; used by the interfaces, the core and the top level.
`default_nettype none

package kpsh_pkg;

	localparam int unsigned ColW      = 2;
	localparam int unsigned RowW      = 4;
	localparam int unsigned KeyW      = 4;
	localparam int unsigned LenW      = 5;
	localparam int unsigned CharW     = 7;
	localparam logic [LenW-1:0] LineLengthReset = 5'd16;

	localparam logic CmdScan  = 1'b0;
	localparam logic CmdClear = 1'b1;

	localparam logic [CharW-1:0] AsciiZero = 7'h30;
	localparam logic [CharW-1:0] AsciiA    = 7'h41;

	typedef struct packed {
		logic            cmd;
		logic [RowW-1:0] row_levels;
	} in_word_t;

	typedef struct packed {
		logic [RowW-1:0]  column_drive;
		logic             char_valid;
		logic [CharW-1:0] char_code;
		logic             clear_display;
		logic             ambiguous_press;
	} out_word_t;

	function automatic logic [CharW-1:0] hex_ascii(input logic [KeyW-1:0] k);
		logic [CharW-1:0] k_ext;
		k_ext = {{(CharW-KeyW){1'b0}}, k};
		if (k < 4'd10) begin
			return AsciiZero + k_ext;
		end else begin
			return AsciiA + k_ext - 7'd10;
		end
	endfunction

endpackage

`default_nettype wire

### sv/kpsh_if.sv
// Valid/ready channel interfaces for the keypad scanner.
// Depends on kpsh_pkg for the word layouts.
`default_nettype none

interface kpsh_in_if;
	logic               valid;
	logic               ready;
	kpsh_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface kpsh_out_if;
	logic                valid;
	logic                ready;
	kpsh_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/kpsh_core.sv
// Scan state and per-tick decode: column counter, line counter, key flags.
// Produces the result word for each accepted input word. Depends on kpsh_pkg.
`default_nettype none

module kpsh_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      fire,
	input  wire kpsh_pkg::in_word_t        in_word,
	input  wire logic [kpsh_pkg::LenW-1:0] line_length,
	output kpsh_pkg::out_word_t            result
);

	logic [kpsh_pkg::ColW-1:0] scan_column_q;
	logic [kpsh_pkg::LenW-1:0] chars_written_q;
	logic [kpsh_pkg::KeyW-1:0] last_key_q;
	logic                      pressed_q;
	logic                      idle_q;

	logic [kpsh_pkg::RowW-1:0] low_rows;
	logic                      any_low;
	logic                      multi_low;
	logic                      scan;
	logic [1:0]                row;
	logic [kpsh_pkg::KeyW-1:0] key;
	logic                      single;
	logic                      emit;
	logic [kpsh_pkg::ColW-1:0] col_next;
	logic                      pressed_next;
	logic                      sweep_end;

	assign scan      = (in_word.cmd == kpsh_pkg::CmdScan);
	assign low_rows  = ~in_word.row_levels;
	assign any_low   = |low_rows;
	assign multi_low = (low_rows & (low_rows - 4'd1)) != 4'd0;
	assign single    = scan && any_low && !multi_low;

	always_comb begin
		case (low_rows)
			4'b0001: row = 2'd0;
			4'b0010: row = 2'd1;
			4'b0100: row = 2'd2;
			default: row = 2'd3;
		endcase
	end

	assign key  = {row, scan_column_q};
	assign emit = single && (chars_written_q < line_length)
		&& ((key != last_key_q) || idle_q);

	assign col_next     = scan ? scan_column_q + 2'd1 : scan_column_q;
	assign pressed_next = pressed_q | (scan && any_low);
	assign sweep_end    = scan && (scan_column_q == 2'd3);

	always_comb begin
		result                 = '0;
		result.column_drive    = ~(4'b0001 << col_next);
		result.char_valid      = emit;
		result.char_code       = emit ? kpsh_pkg::hex_ascii(key) : '0;
		result.clear_display   = !scan;
		result.ambiguous_press = scan && multi_low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_column_q   <= '0;
			chars_written_q <= '0;
			last_key_q      <= '0;
			pressed_q       <= 1'b0;
			idle_q          <= 1'b1;
		end else if (fire) begin
			scan_column_q <= col_next;
			if (!scan) begin
				chars_written_q <= '0;
			end else if (emit) begin
				chars_written_q <= chars_written_q + 5'd1;
			end
			if (single) begin
				last_key_q <= key;
			end
			// close the sweep: idle flag comes from this sweep's presses
			if (sweep_end) begin
				idle_q    <= !pressed_next;
				pressed_q <= 1'b0;
			end else begin
				pressed_q <= pressed_next;
			end
		end
	end

	a_col_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && scan |=> scan_column_q == $past(scan_column_q) + 2'd1)
		else $error("scan column did not advance on a scan tick");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> chars_written_q == $past(chars_written_q) + 5'd1)
		else $error("line counter did not advance on an emitted character");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !scan |=> chars_written_q == '0 && scan_column_q == $past(scan_column_q))
		else $error("clear event did not empty the line or moved the column");

	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(~result.column_drive))
		else $error("column drive does not have exactly one low bit");

	a_no_emit_multi: assert property (@(posedge clk) disable iff (!arst_n)
		result.ambiguous_press |-> !result.char_valid)
		else $error("character emitted on an ambiguous press");

endmodule

`default_nettype wire

### sv/keypad_scan_hex_entry_top.sv
// 4x4 matrix keypad scanner with hexadecimal line entry.
// Channels: keys (sink) takes one word per scan tick or clear event: cmd = 0 with
//   the active-low row levels sampled under the current column, or cmd = 1 to
//   empty the line. result (source) returns exactly one word per input word:
//   the active-low column drive for the next tick, the emitted hex ASCII char
//   (char_valid), the clear flag and the ambiguous-press flag.
// Configuration: cfg_we/cfg_wdata set the line length (reset 16); write only
//   while no word is in flight.
// Result: the result word is registered and valid in the cycle after its input is accepted.
// Throughput: one word per cycle while result.ready is high or the register is empty;
//   decode and state update are combinational between the input handshake and the result register.
// Stall: the result register holds while result.ready is low; keys.ready stays
//   high as long as the register is empty or being drained in the same cycle.
// Reset: column 0, empty line, last key 0, previous sweep idle, no result
//   pending.
// Depends on kpsh_pkg, kpsh_if.sv and kpsh_core.
`default_nettype none

module keypad_scan_hex_entry_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	kpsh_in_if.sink                        keys,
	kpsh_out_if.source                     result,
	input  wire logic                      cfg_we,
	input  wire logic [kpsh_pkg::LenW-1:0] cfg_wdata
);

	logic [kpsh_pkg::LenW-1:0] line_length_q;
	logic                      valid_q;
	kpsh_pkg::out_word_t       word_q;
	kpsh_pkg::out_word_t       core_word;
	logic                      fire;

	assign keys.ready = !valid_q || result.ready;
	assign fire       = keys.valid && keys.ready;

	kpsh_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.in_word     (keys.data),
		.line_length (line_length_q),
		.result      (core_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= kpsh_pkg::LineLengthReset;
		end else if (cfg_we) begin
			line_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			word_q <= core_word;
		end
	end

	assign result.valid = valid_q;
	assign result.data  = word_q;

endmodule

`default_nettype wire
